>>> hw/rtl/csp_pkg.sv
// Shared types and character codes for the CIGAR reference span parser.
`default_nettype none

package csp_pkg;

    // Character codes used to classify the incoming stream.
    localparam logic [7:0] C_ZERO      = 8'd48;  // '0'
    localparam logic [7:0] C_NINE      = 8'd57;  // '9'
    localparam logic [7:0] C_INS_LO    = 8'd33;  // '!'
    localparam logic [7:0] C_INS_HI    = 8'd37;  // '%'
    localparam logic [7:0] C_MIS_LO    = 8'd38;  // '&'
    localparam logic [7:0] C_MIS_HI    = 8'd42;  // '*'
    localparam logic [7:0] C_UPPER_A   = 8'd65;  // 'A'
    localparam logic [7:0] C_UPPER_Z   = 8'd90;  // 'Z'
    localparam logic [7:0] C_LOWER_A   = 8'd97;  // 'a'
    localparam logic [7:0] C_LOWER_Z   = 8'd122; // 'z'
    localparam logic [7:0] C_BASE_A    = 8'd65;  // 'A'
    localparam logic [7:0] C_BASE_C    = 8'd67;  // 'C'
    localparam logic [7:0] C_BASE_G    = 8'd71;  // 'G'
    localparam logic [7:0] C_BASE_N    = 8'd78;  // 'N'
    localparam logic [7:0] C_BASE_T    = 8'd84;  // 'T'

    localparam int unsigned SPAN_W = 32;
    localparam logic [SPAN_W-1:0] SPAN_MAX = '1;

    // One character as held in the input register.
    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_char;

    // One finished result.
    typedef struct packed {
        logic [SPAN_W-1:0] span_length;
        logic              saturated;
    } t_result;

endpackage

`default_nettype wire

>>> hw/rtl/csp_char_if.sv
// Handshake interfaces for the character input and the span result channels.
`default_nettype none

interface csp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface csp_span_if;
    logic        valid;
    logic        ready;
    logic [31:0] span_length;
    logic        saturated;

    modport source (output valid, output span_length, output saturated, input ready);
    modport sink   (input valid, input span_length, input saturated, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/csp_update.sv
// Parser state registers and the per-character update logic.
`default_nettype none

module csp_update
    import csp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_step,
    input  wire t_char   i_char,
    output t_result      o_result
);

    logic              r_seen_digit, n_seen_digit;
    logic [SPAN_W-1:0] r_run, n_run;
    logic [SPAN_W-1:0] r_span, n_span;
    logic [SPAN_W-1:0] r_kept, n_kept;
    logic              r_prev_digit, n_prev_digit;
    logic              r_ovf, n_ovf;

    logic              is_digit;
    logic              is_clip;
    logic              is_ins;
    logic              is_mis;
    logic              is_letter;
    logic [3:0]        digit_val;
    logic [SPAN_W+3:0] run_x10;
    logic [SPAN_W-1:0] add_op;
    logic [SPAN_W:0]   span_sum;

    // Classify the character.
    always_comb begin
        is_digit  = (i_char.char_code >= C_ZERO) && (i_char.char_code <= C_NINE);
        is_ins    = (i_char.char_code >= C_INS_LO) && (i_char.char_code <= C_INS_HI);
        is_mis    = (i_char.char_code >= C_MIS_LO) && (i_char.char_code <= C_MIS_HI);
        is_letter = ((i_char.char_code >= C_UPPER_A) && (i_char.char_code <= C_UPPER_Z))
                 || ((i_char.char_code >= C_LOWER_A) && (i_char.char_code <= C_LOWER_Z));
        is_clip   = (i_char.char_code == C_BASE_A) || (i_char.char_code == C_BASE_T)
                 || (i_char.char_code == C_BASE_G) || (i_char.char_code == C_BASE_C)
                 || (i_char.char_code == C_BASE_N);
        digit_val = 4'(i_char.char_code - C_ZERO);
    end

    // Decimal accumulation as x*8 + x*2 + digit, and the span addition.
    always_comb begin
        run_x10  = {1'b0, r_run, 3'b000} + {3'b000, r_run, 1'b0}
                 + {{(SPAN_W){1'b0}}, digit_val};
        add_op   = is_mis ? SPAN_W'(1) : r_run;
        span_sum = {1'b0, r_span} + {1'b0, add_op};
    end

    // Next state for one character.
    always_comb begin
        n_seen_digit = r_seen_digit;
        n_run        = r_run;
        n_span       = r_span;
        n_kept       = r_kept;
        n_prev_digit = r_prev_digit;
        n_ovf        = r_ovf;
        if (is_digit) begin
            if (run_x10[SPAN_W+3:SPAN_W] != 4'd0) begin
                n_run = SPAN_MAX;
                n_ovf = 1'b1;
            end else begin
                n_run = run_x10[SPAN_W-1:0];
            end
            n_seen_digit = 1'b1;
            n_prev_digit = 1'b1;
        end else if (r_seen_digit) begin
            if (is_ins || is_mis || is_letter) begin
                n_run = '0;
                if (span_sum[SPAN_W]) begin
                    n_span = SPAN_MAX;
                    n_ovf  = 1'b1;
                end else begin
                    n_span = span_sum[SPAN_W-1:0];
                end
            end
            // A clip base right after a digit closes the counted region there.
            if (!is_clip) begin
                n_kept = n_span;
            end else if (r_prev_digit) begin
                n_kept = r_span;
            end
            n_prev_digit = 1'b0;
        end
    end

    assign o_result.span_length = n_kept;
    assign o_result.saturated   = n_ovf;

    // State update; the last character of a string clears everything.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_digit <= 1'b0;
            r_run        <= '0;
            r_span       <= '0;
            r_kept       <= '0;
            r_prev_digit <= 1'b0;
            r_ovf        <= 1'b0;
        end else if (i_step) begin
            if (i_char.last_char) begin
                r_seen_digit <= 1'b0;
                r_run        <= '0;
                r_span       <= '0;
                r_kept       <= '0;
                r_prev_digit <= 1'b0;
                r_ovf        <= 1'b0;
            end else begin
                r_seen_digit <= n_seen_digit;
                r_run        <= n_run;
                r_span       <= n_span;
                r_kept       <= n_kept;
                r_prev_digit <= n_prev_digit;
                r_ovf        <= n_ovf;
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/cigar_reference_span_parser_core.sv
// Top level of the CIGAR reference span parser: input register, update and result register.
//
//   Channel   Dir   Word                          Handshake
//   i_char    in    char_code[7:0], last_char     valid/ready
//   o_span    out   span_length[31:0], saturated  valid/ready
//
// One character is taken per cycle unless a held last character waits on a blocked result.
// A character passes the input register and then updates the parser state; a last
// character also loads the result register.
// Reset clears the state and both valid flags. A stalled result holds the last character
// in the input register; other characters keep flowing past a waiting result.
`default_nettype none

module cigar_reference_span_parser_core
    import csp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    csp_char_if.sink   i_char,
    csp_span_if.source o_span
);

    logic    r_in_valid;
    t_char   r_in;
    logic    r_out_valid;
    t_result r_out;

    logic    out_free;
    logic    advance;
    t_char   in_word;
    t_result result;

    // The input stage moves on unless it holds a last character and the result is blocked.
    assign out_free      = !r_out_valid || o_span.ready;
    assign advance       = !r_in_valid || !r_in.last_char || out_free;
    assign i_char.ready  = advance;
    assign in_word.char_code = i_char.char_code;
    assign in_word.last_char = i_char.last_char;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (advance) begin
            r_in_valid <= i_char.valid;
        end
        if (advance && i_char.valid) begin
            r_in <= in_word;
        end
    end

    csp_update u_update (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (r_in_valid && advance),
        .i_char   (r_in),
        .o_result (result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_in_valid && r_in.last_char && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_span.ready) begin
            r_out_valid <= 1'b0;
        end
        if (r_in_valid && r_in.last_char && out_free) begin
            r_out <= result;
        end
    end

    assign o_span.valid       = r_out_valid;
    assign o_span.span_length = r_out.span_length;
    assign o_span.saturated   = r_out.saturated;

    // A last character leaving the input stage always yields a result word.
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_in.last_char && advance |=> o_span.valid)
        else $error("last character did not produce a result");

    // Input is refused only while a result waits and a last character is held.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_char.ready |-> o_span.valid && !o_span.ready && r_in_valid && r_in.last_char)
        else $error("input stalled without a blocked result");

    // Reset leaves no result pending.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_span.valid)
        else $error("result valid after reset");

endmodule

`default_nettype wire
